// ----- src/pbr_pkg.sv -----
// Shared constants, encodings and command type for the branch relocator.
`timescale 1ns / 1ps

package pbr_pkg;

   // primary opcode field, instruction bits 31:26
   localparam logic [5:0] PO_B  = 6'h12;
   localparam logic [5:0] PO_BC = 6'h10;

   localparam logic [31:0] ENC_LIS   = 32'h3C00_0000;
   localparam logic [31:0] ENC_ORI   = 32'h6000_0000;
   localparam logic [31:0] ENC_MTCTR = 32'h7C09_03A6;
   localparam logic [31:0] ENC_BCCTR = 32'h4C00_0420;
   localparam logic [31:0] ENC_STD   = 32'hF800_0000;
   localparam logic [31:0] ENC_LD    = 32'hE800_0000;

   // -0x30 as a DS displacement, low two bits clear
   localparam logic [15:0] RED_ZONE_DISP = 16'hFFD0;
   localparam logic [4:0]  REG_SP        = 5'd1;
   localparam logic [4:0]  REG_SCRATCH   = 5'd0;
   localparam logic [4:0]  BO_ALWAYS     = 5'd20;
   localparam logic [4:0]  BI_NONE       = 5'd0;

   localparam logic OPC_RELOCATE = 1'b0;
   localparam logic OPC_FAR      = 1'b1;

   // one classified item handed from front to back
   typedef struct packed {
      logic        far;     // 0: emit value as a single word
      logic [31:0] value;   // pass-through word or branch target
      logic [4:0]  bo;
      logic [4:0]  bi;
      logic        lk;
      logic        keep;    // save/restore scratch around the sequence
      logic [4:0]  gpr;
   } cmd_type;

endpackage

// ----- src/pbr_if.sv -----
// Request and response channel interfaces of the branch relocator.
`timescale 1ns / 1ps

interface pbr_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] instr_word;
   logic [31:0] instr_address;
   logic [31:0] branch_target;
   logic [4:0]  cond_bo;
   logic [4:0]  cond_bi;
   logic        link_flag;
   logic        save_scratch;
   logic [4:0]  scratch_reg;

   modport source (output valid, opcode, instr_word, instr_address, branch_target,
                   cond_bo, cond_bi, link_flag, save_scratch, scratch_reg,
                   input ready);
   modport sink (input valid, opcode, instr_word, instr_address, branch_target,
                 cond_bo, cond_bi, link_flag, save_scratch, scratch_reg,
                 output ready);
endinterface

interface pbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_word;
   logic        last_word;

   modport source (output valid, code_word, last_word, input ready);
   modport sink (input valid, code_word, last_word, output ready);
endinterface

// ----- src/pbr_front.sv -----
// Front end: accepts requests, decodes branches, computes targets, registers a command.
`timescale 1ns / 1ps

module pbr_front (
   input  logic             clock,
   input  logic             reset,
   pbr_req_if.sink          req_chan,
   output logic             cmd_valid,
   output pbr_pkg::cmd_type cmd,
   input  logic             cmd_ready
);

   logic             cmd_valid_ff, cmd_valid_in;
   pbr_pkg::cmd_type cmd_ff, cmd_in;
   logic [5:0]       po;
   logic             is_b, is_bc, relative;
   logic [31:0]      offset;
   logic             take;

   assign req_chan.ready = !cmd_valid_ff || cmd_ready;
   assign take           = req_chan.valid && req_chan.ready;

   assign po       = req_chan.instr_word[31:26];
   assign is_b     = (po == pbr_pkg::PO_B);
   assign is_bc    = (po == pbr_pkg::PO_BC);
   assign relative = (is_b || is_bc) && !req_chan.instr_word[1];

   always_comb begin
      if (is_b) begin
         offset = {{6{req_chan.instr_word[25]}}, req_chan.instr_word[25:2], 2'b00};
      end else begin
         offset = {{16{req_chan.instr_word[15]}}, req_chan.instr_word[15:2], 2'b00};
      end
   end

   always_comb begin
      cmd_in = cmd_ff;
      if (take) begin
         if (req_chan.opcode == pbr_pkg::OPC_FAR) begin
            cmd_in.far   = 1'b1;
            cmd_in.value = req_chan.branch_target;
            cmd_in.bo    = req_chan.cond_bo;
            cmd_in.bi    = req_chan.cond_bi;
            cmd_in.lk    = req_chan.link_flag;
            cmd_in.keep  = req_chan.save_scratch;
            cmd_in.gpr   = req_chan.scratch_reg;
         end else begin
            cmd_in.far   = relative;
            cmd_in.value = relative ? req_chan.instr_address + offset
                                    : req_chan.instr_word;
            cmd_in.bo    = is_b ? pbr_pkg::BO_ALWAYS : req_chan.instr_word[25:21];
            cmd_in.bi    = is_b ? pbr_pkg::BI_NONE   : req_chan.instr_word[20:16];
            cmd_in.lk    = req_chan.instr_word[0];
            cmd_in.keep  = 1'b1;
            cmd_in.gpr   = pbr_pkg::REG_SCRATCH;
         end
      end
   end

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      if (take) begin
         cmd_valid_in = 1'b1;
      end else if (cmd_ready) begin
         cmd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ----- src/pbr_queue.sv -----
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module pbr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  pbr_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             head_valid,
   output pbr_pkg::cmd_type head_cmd,
   input  logic             pop
);

   pbr_pkg::cmd_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/pbr_back.sv -----
// Back end: steps through the emitted word sequence into the response register.
`timescale 1ns / 1ps

module pbr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pbr_pkg::cmd_type head_cmd,
   output logic             pop,
   pbr_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {
      STEP_STD,
      STEP_LIS,
      STEP_ORI,
      STEP_MTCTR,
      STEP_LD,
      STEP_BCCTR
   } step_type;

   step_type    step_ff, step_in, cur_step;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        advance, is_last;
   logic [31:0] word;
   logic [31:0] r21, r16;

   assign advance = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign r21     = {6'd0, head_cmd.gpr, 21'd0};
   assign r16     = {11'd0, head_cmd.gpr, 16'd0};

   // without a scratch save the sequence starts at lis
   assign cur_step = (step_ff == STEP_STD && !head_cmd.keep) ? STEP_LIS : step_ff;
   assign is_last  = !head_cmd.far || (cur_step == STEP_BCCTR);
   assign pop      = advance && is_last;

   always_comb begin
      step_in = cur_step;
      word    = head_cmd.value;
      unique case (cur_step)
         STEP_STD: begin
            word    = pbr_pkg::ENC_STD | r21 | {11'd0, pbr_pkg::REG_SP, 16'd0}
                      | {16'd0, pbr_pkg::RED_ZONE_DISP};
            step_in = STEP_LIS;
         end
         STEP_LIS: begin
            word    = pbr_pkg::ENC_LIS | r21 | {16'd0, head_cmd.value[31:16]};
            step_in = STEP_ORI;
         end
         STEP_ORI: begin
            word    = pbr_pkg::ENC_ORI | r21 | r16 | {16'd0, head_cmd.value[15:0]};
            step_in = STEP_MTCTR;
         end
         STEP_MTCTR: begin
            word    = pbr_pkg::ENC_MTCTR | r21;
            step_in = head_cmd.keep ? STEP_LD : STEP_BCCTR;
         end
         STEP_LD: begin
            word    = pbr_pkg::ENC_LD | r21 | {11'd0, pbr_pkg::REG_SP, 16'd0}
                      | {16'd0, pbr_pkg::RED_ZONE_DISP};
            step_in = STEP_BCCTR;
         end
         STEP_BCCTR: begin
            word    = pbr_pkg::ENC_BCCTR | {6'd0, head_cmd.bo, 21'd0}
                      | {11'd0, head_cmd.bi, 16'd0} | {31'd0, head_cmd.lk};
            step_in = STEP_STD;
         end
         default: begin
            word    = head_cmd.value;
            step_in = STEP_STD;
         end
      endcase
      if (!head_cmd.far) begin
         word    = head_cmd.value;
         step_in = STEP_STD;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = word;
         rsp_last_in  = is_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_STD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            step_ff <= step_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.code_word = rsp_word_ff;
   assign rsp_chan.last_word = rsp_last_ff;

endmodule

// ----- src/ppc_branch_relocator.sv -----
// Top level of the PowerPC branch relocator.
// Usage:
//   req_chan carries one instruction (opcode 0) or one far-branch request (opcode 1).
//   rsp_chan returns the emitted code words, one per transaction, with last_word
//   set on the final word of each request.
//   A non-branch or absolute branch word yields 1 word; a relative b/bc yields 6;
//   an explicit far branch yields 4, or 6 with save_scratch.
// Path: with the pipeline empty, the first word of a request is registered in turn by
//   the front register at acceptance, then the queue, then the response register.
// Throughput: one code word per cycle while rsp_chan.ready stays high, limited by the
//   back-end word sequencer, so a request occupies the back end for 1, 4 or 6 words;
//   requests are taken back to back while the front register and the two-entry queue have room.
// Reset: synchronous, active high; clears all valid state and the sequencer,
//   dropping any request in flight.
// Stall: when rsp_chan.ready is low the current word holds; the queue fills and
//   then req_chan.ready falls.
`timescale 1ns / 1ps

module ppc_branch_relocator (
   input  logic       clock,
   input  logic       reset,
   pbr_req_if.sink    req_chan,
   pbr_rsp_if.source  rsp_chan
);

   logic             cmd_valid, cmd_ready;
   pbr_pkg::cmd_type cmd;
   logic             head_valid, pop;
   pbr_pkg::cmd_type head_cmd;

   pbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   pbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_cmd   (cmd),
      .push_ready (cmd_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   pbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- src/pbr_checker.sv -----
// Port-level checker for the branch relocator, with its bind.
`timescale 1ns / 1ps

module pbr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   logic [3:0] pending_ff, pending_in;
   logic [2:0] run_ff, run_in;
   logic       req_take, rsp_take, rsp_end;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign rsp_end  = rsp_take && rsp_last;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_end) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_end && !req_take) begin
         pending_in = pending_ff - 4'd1;
      end
      run_in = run_ff;
      if (rsp_take) begin
         run_in = rsp_last ? 3'd0 : run_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 4'd0;
         run_ff     <= 3'd0;
      end else begin
         pending_ff <= pending_in;
         run_ff     <= run_in;
      end
   end

   // no response right out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a word only for a request that is still owed words
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> pending_ff != 4'd0)
      else $error("response with no open request");

   // no request expands to more than six words
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && run_ff == 3'd5) |-> rsp_last)
      else $error("request ran past six words");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response valid dropped while stalled");

endmodule

bind ppc_branch_relocator pbr_checker u_pbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last_word)
);
